// ===== sv/fenwick_point_set_range_sum_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef FENWICK_POINT_SET_RANGE_SUM_MACROS_SVH
`define FENWICK_POINT_SET_RANGE_SUM_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FPSRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fpsrs check failed");

// Condition that must hold in the cycle after a trigger.
`define FPSRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `FPSRS_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ===== sv/fpsrs_pkg.sv =====
package fpsrs_pkg;

  localparam int CAPACITY = 1024;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;
  localparam int ACT_W  = 2;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int WIDE_W = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;
  // One spare bit so that a node index may step past the top of the tree.
  localparam int NODE_W = WIDE_W + 1;

  localparam logic [NODE_W-1:0] CAP_N    = NODE_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(CAPACITY - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_SET = 2'd0,
    ACT_SUM = 2'd1,
    ACT_GET = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY,
    ST_GET_RD,
    ST_GET_WB,
    ST_DROP,
    ST_DONE
  } state_e;

  // Prefix lengths beyond the tree cover every element.
  function automatic logic [NODE_W-1:0] sat_len(input logic [NODE_W-1:0] len);
    sat_len = (len > CAP_N) ? CAP_N : len;
  endfunction

endpackage

// ===== sv/fenwick_point_set_range_sum.sv =====
// Fenwick tree over CAPACITY signed 32-bit elements (1024 in this build) with point
// assignment, inclusive range sums and single-element reads; all sums wrap modulo
// 2^32. After reset the block runs a clearing pass over every address that zeroes
// both memories, holding in_stall_o high throughout. An item is then taken when the
// block is idle, one item at a time; the cost is set by the single port of the tree
// memory. A set reads the old element, writes the new one, then reads and writes back
// each node on the upward path from index_lo+1, at most 11 nodes here. A range sum
// reads the nodes on the two downward paths, popcount(index_hi+1) + popcount(index_lo)
// reads, at most 20 nodes, adding the first path and subtracting the second as the
// data returns. A read fetches the single element, and an unused action code is
// dropped. A finished result sits in the output register, and the next item is
// accepted while it waits there; the following result is only written once that
// register has been taken. A range sum with index_lo above index_hi returns the
// plain wrapped difference of the two prefixes, a set or read beyond the capacity
// is ignored or answers zero, and a prefix length past the capacity covers all
// elements.
module fenwick_point_set_range_sum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fpsrs_pkg::ACT_W-1:0]  action_i,
  input  logic [fpsrs_pkg::IDX_W-1:0]  index_lo_i,
  input  logic [fpsrs_pkg::IDX_W-1:0]  index_hi_i,
  input  logic signed [fpsrs_pkg::DATA_W-1:0] new_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [fpsrs_pkg::DATA_W-1:0] answer_o
);

  import fpsrs_pkg::*;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [NODE_W-1:0]   lo_q, lo_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [DATA_W-1:0]   delta_q, delta_d;
  logic [NODE_W-1:0]   node_q, node_d;
  logic [NODE_W-1:0]   len_q, len_d;
  logic [NODE_W-1:0]   len2_q, len2_d;
  logic                phase_q, phase_d;
  logic                rd_pend_q, rd_pend_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   answer_q, answer_d;

  logic                el_we, tr_we;
  logic [ADDR_W-1:0]   el_addr, tr_addr;
  logic [DATA_W-1:0]   el_wdata, tr_wdata;
  logic [DATA_W-1:0]   el_rdata, tr_rdata;

  logic                in_fire;
  logic [NODE_W-1:0]   in_lo_ext, in_hi_len;
  logic [NODE_W-1:0]   node_m1, len_m1;

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign in_lo_ext = NODE_W'(index_lo_i);
  assign in_hi_len = NODE_W'(index_hi_i) + NODE_W'(1);
  assign node_m1   = node_q - NODE_W'(1);
  assign len_m1    = len_q - NODE_W'(1);

  fpsrs_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .addr_i  (el_addr),
    .wdata_i (el_wdata),
    .rdata_o (el_rdata)
  );

  fpsrs_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .addr_i  (tr_addr),
    .wdata_i (tr_wdata),
    .rdata_o (tr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    val_q    <= val_d;
    delta_q  <= delta_d;
    node_q   <= node_d;
    len_q    <= len_d;
    len2_q   <= len2_d;
    acc_q    <= acc_d;
    answer_q <= answer_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    lo_d        = lo_q;
    val_d       = val_q;
    delta_d     = delta_q;
    node_d      = node_q;
    len_d       = len_q;
    len2_d      = len2_q;
    phase_d     = phase_q;
    rd_pend_d   = rd_pend_q;
    acc_d       = acc_q;
    answer_d    = answer_q;
    out_valid_d = out_valid_q && out_stall_i;

    el_we    = 1'b0;
    el_addr  = lo_q[ADDR_W-1:0];
    el_wdata = val_q;
    tr_we    = 1'b0;
    tr_addr  = node_m1[ADDR_W-1:0];
    tr_wdata = tr_rdata + delta_q;

    case (state_q)
      ST_CLEAR: begin
        // Zero one entry of each memory per cycle.
        el_we    = 1'b1;
        el_addr  = clr_q;
        el_wdata = '0;
        tr_we    = 1'b1;
        tr_addr  = clr_q;
        tr_wdata = '0;
        if (clr_q == LAST_ADR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          lo_d    = in_lo_ext;
          val_d   = new_value_i;
          acc_d   = '0;
          phase_d = 1'b0;
          len_d   = sat_len(in_hi_len);
          len2_d  = sat_len(in_lo_ext);
          case (action_i)
            ACT_SET: state_d = (in_lo_ext < CAP_N) ? ST_SET_RD : ST_DROP;
            ACT_SUM: state_d = ST_QRY;
            ACT_GET: state_d = (in_lo_ext < CAP_N) ? ST_GET_RD : ST_DONE;
            default: state_d = ST_DROP;
          endcase
        end
      end

      ST_SET_RD: begin
        state_d = ST_SET_WR;
      end

      ST_SET_WR: begin
        // Old element arrives; store the new one and keep the difference.
        delta_d = val_q - el_rdata;
        el_we   = 1'b1;
        node_d  = lo_q + NODE_W'(1);
        state_d = ST_UPD_RD;
      end

      ST_UPD_RD: begin
        if (node_q > CAP_N) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_UPD_WR;
        end
      end

      ST_UPD_WR: begin
        // Read-modify-write of one node, then climb to the next covering node.
        tr_we   = 1'b1;
        node_d  = node_q + (node_q & (~node_q + NODE_W'(1)));
        state_d = ST_UPD_RD;
      end

      ST_QRY: begin
        // Downward walk: one node read per cycle, summed when the data returns.
        tr_addr = len_m1[ADDR_W-1:0];
        if (rd_pend_q) begin
          acc_d = phase_q ? (acc_q - tr_rdata) : (acc_q + tr_rdata);
        end
        if (len_q != '0) begin
          len_d     = len_q & len_m1;
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            if (!phase_q) begin
              phase_d = 1'b1;
              len_d   = len2_q;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_GET_RD: begin
        state_d = ST_GET_WB;
      end

      ST_GET_WB: begin
        acc_d   = el_rdata;
        state_d = ST_DONE;
      end

      ST_DROP: begin
        state_d = ST_IDLE;
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          answer_d    = acc_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

endmodule

// ===== sv/fpsrs_ram.sv =====
module fpsrs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read; a read during a write returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fpsrs_checker.sv =====
`include "fenwick_point_set_range_sum_macros.svh"

module fpsrs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [fpsrs_pkg::DATA_W-1:0] answer_o
);

  // The clearing pass keeps the input stalled right after reset.
  `FPSRS_ASSERT(a_clear_stalls, clk_i, rst_ni, !$past(rst_ni) |-> in_stall_o)

  // Accepting an item raises the input stall.
  `FPSRS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `FPSRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `FPSRS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(answer_o))

endmodule

bind fenwick_point_set_range_sum fpsrs_checker u_fpsrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .answer_o    (answer_o)
);
